>>> hw/rtl/gspe_pkg.sv
package gspe_pkg;

  localparam int MAX_NODES_DEF   = 32;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int COST_MAX        = 2097151;
  localparam logic [5:0] NODE_COUNT_RST = 6'd32;

  localparam logic [1:0] F_ADD   = 2'd0;
  localparam logic [1:0] F_DEL   = 2'd1;
  localparam logic [1:0] F_QUERY = 2'd2;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_SAME   = 3'd1;
  localparam logic [2:0] ST_BAD    = 3'd2;
  localparam logic [2:0] ST_EXISTS = 3'd3;
  localparam logic [2:0] ST_DISC   = 3'd4;

  typedef struct packed {
    logic       take;
    logic       conn_init;
    logic       set_resp;
    logic [2:0] resp;
    logic       resp_emit;
    logic       mem_rd_ab;
    logic       mem_wr_ab;
    logic       mem_wr_ba;
    logic       wr_edge;
    logic       conn_pick;
    logic       row_rd;
    logic       row_conn;
    logic       scan_clr;
    logic       q_init;
    logic       sel_step;
    logic       settle;
    logic       path_init;
    logic       path_emit;
  } cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic       fire;
    logic [1:0] func;
    logic       same;
    logic       bad;
    logic       edge_exists;
    logic       pending;
    logic       conn_ok;
    logic       scan_end;
    logic       found;
    logic       best_is_t;
    logic       out_space;
    logic       path_last;
  } sts_t;

endpackage

>>> hw/rtl/gspe_ifs.sv
interface gspe_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [5:0]  node_a;
  logic [5:0]  node_b;
  logic [15:0] weight;
  modport source (output valid, func, node_a, node_b, weight, input ready);
  modport sink (input valid, func, node_a, node_b, weight, output ready);
endinterface

interface gspe_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [5:0]  vertex;
  logic [20:0] path_cost;
  logic        last;
  modport source (output valid, status, vertex, path_cost, last, input ready);
  modport sink (input valid, status, vertex, path_cost, last, output ready);
endinterface

interface gspe_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> hw/rtl/gspe_ctrl.sv
module gspe_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  gspe_pkg::sts_t sts,
  output gspe_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_ADD       = 4'd1;
  localparam logic [3:0] S_ADD_CHK   = 4'd2;
  localparam logic [3:0] S_ADD_W2    = 4'd3;
  localparam logic [3:0] S_DEL       = 4'd4;
  localparam logic [3:0] S_DEL_W2    = 4'd5;
  localparam logic [3:0] S_RESP      = 4'd6;
  localparam logic [3:0] S_CONN_PICK = 4'd7;
  localparam logic [3:0] S_CONN_SCAN = 4'd8;
  localparam logic [3:0] S_CONN_END  = 4'd9;
  localparam logic [3:0] S_Q_INIT    = 4'd10;
  localparam logic [3:0] S_SEL       = 4'd11;
  localparam logic [3:0] S_SEL_END   = 4'd12;
  localparam logic [3:0] S_RELAX     = 4'd13;
  localparam logic [3:0] S_PATH_INIT = 4'd14;
  localparam logic [3:0] S_PATH      = 4'd15;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.take = sts.clr_done;
        if (sts.fire) begin
          case (sts.func)
            gspe_pkg::F_ADD:   state_next = S_ADD;
            gspe_pkg::F_DEL:   state_next = S_DEL;
            gspe_pkg::F_QUERY: begin
              cmd.conn_init = 1'b1;
              state_next = S_CONN_PICK;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        if (sts.same) begin
          cmd.set_resp = 1'b1;
          cmd.resp = gspe_pkg::ST_SAME;
          state_next = S_RESP;
        end else if (sts.bad) begin
          cmd.set_resp = 1'b1;
          cmd.resp = gspe_pkg::ST_BAD;
          state_next = S_RESP;
        end else begin
          cmd.mem_rd_ab = 1'b1;
          state_next = S_ADD_CHK;
        end
      end
      S_ADD_CHK: begin
        if (sts.edge_exists) begin
          cmd.set_resp = 1'b1;
          cmd.resp = gspe_pkg::ST_EXISTS;
          state_next = S_RESP;
        end else begin
          cmd.mem_wr_ab = 1'b1;
          cmd.wr_edge = 1'b1;
          state_next = S_ADD_W2;
        end
      end
      S_ADD_W2: begin
        cmd.mem_wr_ba = 1'b1;
        cmd.wr_edge = 1'b1;
        cmd.set_resp = 1'b1;
        cmd.resp = gspe_pkg::ST_OK;
        state_next = S_RESP;
      end
      S_DEL: begin
        cmd.set_resp = 1'b1;
        if (sts.bad) begin
          cmd.resp = gspe_pkg::ST_BAD;
          state_next = S_RESP;
        end else if (sts.same) begin
          cmd.resp = gspe_pkg::ST_OK;
          state_next = S_RESP;
        end else begin
          cmd.set_resp = 1'b0;
          cmd.mem_wr_ab = 1'b1;
          state_next = S_DEL_W2;
        end
      end
      S_DEL_W2: begin
        cmd.mem_wr_ba = 1'b1;
        cmd.set_resp = 1'b1;
        cmd.resp = gspe_pkg::ST_OK;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (sts.out_space) begin
          cmd.resp_emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CONN_PICK: begin
        if (sts.pending) begin
          cmd.conn_pick = 1'b1;
          state_next = S_CONN_SCAN;
        end else begin
          state_next = S_CONN_END;
        end
      end
      S_CONN_SCAN: begin
        if (!sts.scan_end) begin
          cmd.row_rd = 1'b1;
          cmd.row_conn = 1'b1;
        end else begin
          state_next = S_CONN_PICK;
        end
      end
      S_CONN_END: begin
        cmd.set_resp = 1'b1;
        state_next = S_RESP;
        if (!sts.conn_ok) begin
          cmd.resp = gspe_pkg::ST_DISC;
        end else if (sts.same) begin
          cmd.resp = gspe_pkg::ST_SAME;
        end else if (sts.bad) begin
          cmd.resp = gspe_pkg::ST_BAD;
        end else begin
          cmd.set_resp = 1'b0;
          state_next = S_Q_INIT;
        end
      end
      S_Q_INIT: begin
        cmd.q_init = 1'b1;
        state_next = S_SEL;
      end
      S_SEL: begin
        if (!sts.scan_end) begin
          cmd.sel_step = 1'b1;
        end else begin
          state_next = S_SEL_END;
        end
      end
      S_SEL_END: begin
        if (!sts.found) begin
          state_next = S_PATH_INIT;
        end else begin
          cmd.settle = 1'b1;
          state_next = sts.best_is_t ? S_PATH_INIT : S_RELAX;
        end
      end
      S_RELAX: begin
        if (!sts.scan_end) begin
          cmd.row_rd = 1'b1;
        end else begin
          cmd.scan_clr = 1'b1;
          state_next = S_SEL;
        end
      end
      S_PATH_INIT: begin
        cmd.path_init = 1'b1;
        state_next = S_PATH;
      end
      S_PATH: begin
        if (sts.out_space) begin
          cmd.path_emit = 1'b1;
          if (sts.path_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/gspe_dp.sv
module gspe_dp #(
  parameter int MAX_NODES   = gspe_pkg::MAX_NODES_DEF,
  parameter int WEIGHT_BITS = gspe_pkg::WEIGHT_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  gspe_item_if.sink      item,
  gspe_result_if.source  result,
  gspe_cfg_if.sink       cfg,
  input  gspe_pkg::cmd_t cmd,
  output gspe_pkg::sts_t sts
);

  localparam int IDX = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW  = IDX + 1;
  localparam int DW  = WEIGHT_BITS + IDX;
  localparam int AW  = 2 * IDX;
  localparam int DEPTH = MAX_NODES * MAX_NODES;

  logic [WEIGHT_BITS:0] emem [DEPTH];
  logic [WEIGHT_BITS:0] rd_data;
  logic [AW:0]          clr_cnt;
  logic                 clr_done;

  logic [5:0]             node_count;
  logic [CW-1:0]          n_eff;
  logic [1:0]             func_r;
  logic [5:0]             a_r, b_r;
  logic [WEIGHT_BITS-1:0] w_r;
  logic [IDX-1:0]         ia, ib;

  logic [CW-1:0]        cnt;
  logic [MAX_NODES-1:0] seen, done, reached, settled, act;
  logic [IDX-1:0]       pk, pk_next, best, j_d, cur;
  logic [DW-1:0]        best_dist;
  logic                 found;
  logic                 rd_conn_d, rd_relax_d;
  logic [DW-1:0]        node_dist [MAX_NODES];
  logic [IDX-1:0]       pred [MAX_NODES];
  logic [IDX-1:0]       dist_idx;
  logic [DW-1:0]        dist_rd, nd;
  logic [CW-1:0]        steps;
  logic [20:0]          cost;
  logic [20:0]          q_cost;
  logic [63:0]          dist_wide;
  logic                 path_last;
  logic [2:0]           resp;

  logic        o_valid, o_last;
  logic [2:0]  o_status;
  logic [5:0]  o_vertex;
  logic [20:0] o_cost;

  logic          we;
  logic [AW-1:0] wa, ra;
  logic [WEIGHT_BITS:0] wd;
  logic          e_valid;
  logic          fire, out_space;

  assign clr_done = clr_cnt[AW];
  assign fire = item.valid && item.ready;
  assign item.ready = cmd.take;
  assign cfg.ready = 1'b1;
  assign out_space = !o_valid || result.ready;

  always_comb begin
    if (node_count == 6'd0) begin
      n_eff = CW'(1);
    end else if (8'(node_count) > 8'(MAX_NODES)) begin
      n_eff = CW'(MAX_NODES);
    end else begin
      n_eff = CW'(node_count);
    end
  end

  assign ia = IDX'(a_r - 6'd1);
  assign ib = IDX'(b_r - 6'd1);

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      act[i] = CW'(i) < n_eff;
    end
    pk_next = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (seen[i] && !done[i]) begin
        pk_next = IDX'(i);
      end
    end
  end

  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = '0;
    if (!clr_done) begin
      we = 1'b1;
      wa = clr_cnt[AW-1:0];
    end else if (cmd.mem_wr_ab || cmd.mem_wr_ba) begin
      we = 1'b1;
      wa = cmd.mem_wr_ab ? {ia, ib} : {ib, ia};
      wd = cmd.wr_edge ? {1'b1, w_r} : '0;
    end
    if (cmd.mem_rd_ab) begin
      ra = {ia, ib};
    end else begin
      ra = {cmd.row_conn ? pk : best, cnt[IDX-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      emem[wa] <= wd;
    end
    rd_data <= emem[ra];
  end

  assign e_valid = rd_data[WEIGHT_BITS];

  always_comb begin
    if (rd_relax_d) begin
      dist_idx = j_d;
    end else if (cmd.path_init) begin
      dist_idx = ib;
    end else begin
      dist_idx = cnt[IDX-1:0];
    end
  end

  assign dist_rd = node_dist[dist_idx];
  assign nd = best_dist + DW'(rd_data[WEIGHT_BITS-1:0]);
  assign dist_wide = 64'(dist_rd);
  assign cost = (dist_wide > 64'(gspe_pkg::COST_MAX)) ? 21'(gspe_pkg::COST_MAX)
                                                      : dist_wide[20:0];
  assign path_last = (cur == ia) || (steps == n_eff - CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      node_count <= gspe_pkg::NODE_COUNT_RST;
      rd_conn_d <= 1'b0;
      rd_relax_d <= 1'b0;
      settled <= '0;
      o_valid <= 1'b0;
    end else begin
      if (!clr_done) begin
        clr_cnt <= clr_cnt + (AW + 1)'(1);
      end
      if (cfg.valid) begin
        node_count <= cfg.data;
      end
      rd_conn_d <= cmd.row_rd && cmd.row_conn;
      rd_relax_d <= cmd.row_rd && !cmd.row_conn;
      if (cmd.q_init) begin
        settled <= '0;
      end else if (cmd.settle) begin
        settled[best] <= 1'b1;
      end
      if (cmd.resp_emit || cmd.path_emit) begin
        o_valid <= 1'b1;
      end else if (result.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      func_r <= item.func;
      a_r <= item.node_a;
      b_r <= item.node_b;
      w_r <= WEIGHT_BITS'(item.weight);
    end
    if (cmd.set_resp) begin
      resp <= cmd.resp;
    end
    if (cmd.row_rd) begin
      j_d <= cnt[IDX-1:0];
    end
    if (cmd.conn_pick || cmd.q_init || cmd.settle || cmd.scan_clr) begin
      cnt <= '0;
    end else if (cmd.row_rd || cmd.sel_step) begin
      cnt <= cnt + CW'(1);
    end
    if (cmd.conn_init) begin
      seen <= MAX_NODES'(1);
      done <= '0;
    end else begin
      if (cmd.conn_pick) begin
        pk <= pk_next;
        done[pk_next] <= 1'b1;
      end
      if (rd_conn_d && e_valid) begin
        seen[j_d] <= 1'b1;
      end
    end
    if (cmd.q_init || cmd.scan_clr) begin
      found <= 1'b0;
    end else if (cmd.sel_step) begin
      if (reached[cnt[IDX-1:0]] && !settled[cnt[IDX-1:0]]
          && (!found || dist_rd < best_dist)) begin
        best <= cnt[IDX-1:0];
        best_dist <= dist_rd;
        found <= 1'b1;
      end
    end
    if (cmd.q_init) begin
      reached <= '0;
      reached[ia] <= 1'b1;
      node_dist[ia] <= '0;
    end else if (rd_relax_d && e_valid && !settled[j_d]
                 && (!reached[j_d] || nd < dist_rd)) begin
      reached[j_d] <= 1'b1;
      node_dist[j_d] <= nd;
      pred[j_d] <= best;
    end
    if (cmd.path_init) begin
      q_cost <= cost;
      cur <= ib;
      steps <= '0;
    end
    if (cmd.resp_emit) begin
      o_status <= resp;
      o_vertex <= '0;
      o_cost <= '0;
      o_last <= 1'b1;
    end else if (cmd.path_emit) begin
      o_status <= gspe_pkg::ST_OK;
      o_vertex <= 6'(cur) + 6'd1;
      o_cost <= q_cost;
      o_last <= path_last;
      cur <= pred[cur];
      steps <= steps + CW'(1);
    end
  end

  assign result.valid = o_valid;
  assign result.status = o_status;
  assign result.vertex = o_vertex;
  assign result.path_cost = o_cost;
  assign result.last = o_last;

  assign sts.clr_done = clr_done;
  assign sts.fire = fire;
  assign sts.func = fire ? item.func : func_r;
  assign sts.same = a_r == b_r;
  assign sts.bad = (a_r == 6'd0) || (b_r == 6'd0) || (8'(a_r) > 8'(n_eff))
                   || (8'(b_r) > 8'(n_eff));
  assign sts.edge_exists = e_valid;
  assign sts.pending = |(seen & ~done);
  assign sts.conn_ok = &(seen | ~act);
  assign sts.scan_end = cnt == n_eff;
  assign sts.found = found;
  assign sts.best_is_t = best == ib;
  assign sts.out_space = out_space;
  assign sts.path_last = path_last;

endmodule

>>> hw/rtl/graph_shortest_path_engine_core.sv
// An add item checks its nodes, looks up the edge, then writes it in both directions;
// a delete item writes both directions. Both then wait for the result port. A query
// runs a connectivity pass, then the search, then emits the path nodes.
// One item is worked on at a time; the adjacency memory read port sets the scan rate.
// After reset the adjacency memory is cleared, one entry per cycle over its whole
// address range, and no item is accepted until that pass ends.
module graph_shortest_path_engine_core #(
  parameter int MAX_NODES   = gspe_pkg::MAX_NODES_DEF,
  parameter int WEIGHT_BITS = gspe_pkg::WEIGHT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  gspe_item_if.sink     item,
  gspe_result_if.source result,
  gspe_cfg_if.sink      cfg
);

  gspe_pkg::cmd_t cmd;
  gspe_pkg::sts_t sts;

  gspe_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  gspe_dp #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cfg    (cfg),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule
